FILE: hdl/argb_pkg.sv
// ----------------------------------------------------------------------------
// argb_pkg
// shared types, register indexes and channel arithmetic for the argb over
// compositor
// ----------------------------------------------------------------------------
package argb_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W = 32;
  localparam int unsigned NUM_CHAN = PIX_W / CHAN_W;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;
  localparam logic [2*CHAN_W-1:0] ROUND_BIAS = 16'h0080;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_OPAQUE  = 3'd0,
    CFG_DST_OPAQUE  = 3'd1,
    CFG_USE_MASK    = 3'd2,
    CFG_USE_SOLID   = 3'd3,
    CFG_SOLID_COLOR = 3'd4
  } cfg_idx_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic copy;
    logic use_mask;
    logic last;
  } ctl_t;

  // a * b / 255 with rounding: t = a*b + 0x80, ((t >> 8) + t) >> 8
  function automatic logic [CHAN_W-1:0] mul8(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    logic [2*CHAN_W-1:0] t;
    logic [2*CHAN_W:0]   u;
    t = (2*CHAN_W)'(a) * (2*CHAN_W)'(b) + ROUND_BIAS;
    u = {1'b0, t} + {{(CHAN_W+1){1'b0}}, t[2*CHAN_W-1:CHAN_W]};
    return u[2*CHAN_W-1:CHAN_W];
  endfunction

  // add with clamp at 255
  function automatic logic [CHAN_W-1:0] addsat8(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[CHAN_W] ? CHAN_MAX : t[CHAN_W-1:0];
  endfunction

endpackage

FILE: hdl/argb_over_compositor_unit.sv
// ----------------------------------------------------------------------------
// argb_over_compositor_unit
// porter-duff over of a premultiplied argb8888 source onto a destination
// ----------------------------------------------------------------------------
// usage:
//   - input channel in_valid/in_ready carries one item: src_pixel, dst_pixel,
//     mask_alpha and row_end; output channel out_valid/out_ready returns one
//     item per input item: result_pixel and last_out (row_end passed along)
//   - cfg_we/cfg_index/cfg_data write the mode bits and the solid color;
//     writes are registered, no read-back, indexes past the solid color
//     are dropped; write only while no item is in flight
//   - four register stages: source select, mask scale, destination scale,
//     saturating add into the output register; each accepted item passes
//     through them in that order, and out_valid rises once it reaches the
//     output register
//   - throughput is one item per clock while out_ready is high; each stage
//     holds one item and the 8x8 multiplies set the stage depth
//   - when out_ready is low, stages fill up behind the output register and
//     in_ready drops only once every stage holds an item; no item is lost
//     or repeated
//   - rst (synchronous) empties the pipeline and clears the configuration registers to 0
// ----------------------------------------------------------------------------
module argb_over_compositor_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [argb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [argb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [argb_pkg::PIX_W-1:0]        src_pixel,
  input  logic [argb_pkg::PIX_W-1:0]        dst_pixel,
  input  logic [argb_pkg::CHAN_W-1:0]       mask_alpha,
  input  logic                              row_end,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [argb_pkg::PIX_W-1:0]        result_pixel,
  output logic                              last_out
);

  localparam int unsigned CW = argb_pkg::CHAN_W;
  localparam int unsigned PW = argb_pkg::PIX_W;
  localparam int unsigned NC = argb_pkg::NUM_CHAN;

  // configuration registers
  logic          src_opaque;
  logic          dst_opaque;
  logic          use_mask;
  logic          use_solid;
  logic [PW-1:0] solid_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_opaque  <= 1'b0;
      dst_opaque  <= 1'b0;
      use_mask    <= 1'b0;
      use_solid   <= 1'b0;
      solid_color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        argb_pkg::CFG_SRC_OPAQUE:  src_opaque  <= cfg_data[0];
        argb_pkg::CFG_DST_OPAQUE:  dst_opaque  <= cfg_data[0];
        argb_pkg::CFG_USE_MASK:    use_mask    <= cfg_data[0];
        argb_pkg::CFG_USE_SOLID:   use_solid   <= cfg_data[0];
        argb_pkg::CFG_SOLID_COLOR: solid_color <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage ready; a stage moves when the next one
  // is empty or moving itself
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: pick the source, force alpha for an opaque pixel source,
  // flag the verbatim copy case
  // ---------------------------------------------------------------------
  argb_pkg::ctl_t  s1_ctl, s1_ctl_next;
  logic [PW-1:0]   s1_src, s1_src_next;
  logic [PW-1:0]   s1_dst;
  logic [CW-1:0]   s1_mask;

  always_comb begin
    s1_ctl_next.copy     = !use_solid && src_opaque && dst_opaque && !use_mask;
    s1_ctl_next.use_mask = use_mask;
    s1_ctl_next.last     = row_end;
    s1_src_next          = use_solid ? solid_color : src_pixel;
    // copy case keeps the top byte as received
    if (!use_solid && src_opaque && !s1_ctl_next.copy) begin
      s1_src_next[PW-1 -: CW] = argb_pkg::CHAN_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_ctl  <= s1_ctl_next;
      s1_src  <= s1_src_next;
      s1_dst  <= dst_pixel;
      s1_mask <= mask_alpha;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: if use_mask, scale all four source channels by the mask coverage
  // ---------------------------------------------------------------------
  argb_pkg::ctl_t  s2_ctl;
  logic [PW-1:0]   s2_src, s2_src_next;
  logic [PW-1:0]   s2_dst;

  always_comb begin
    s2_src_next = s1_src;
    if (s1_ctl.use_mask) begin
      for (int k = 0; k < NC; k++) begin
        s2_src_next[CW*k +: CW] = argb_pkg::mul8(s1_src[CW*k +: CW], s1_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_ctl <= s1_ctl;
      s2_src <= s2_src_next;
      s2_dst <= s1_dst;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: destination times inverse source alpha
  // ---------------------------------------------------------------------
  argb_pkg::ctl_t  s3_ctl;
  logic [PW-1:0]   s3_src;
  logic [PW-1:0]   s3_dmul, s3_dmul_next;
  logic [CW-1:0]   inv_alpha;

  always_comb begin
    inv_alpha = argb_pkg::CHAN_MAX - s2_src[PW-1 -: CW];
    for (int k = 0; k < NC; k++) begin
      s3_dmul_next[CW*k +: CW] = argb_pkg::mul8(s2_dst[CW*k +: CW], inv_alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_ctl  <= s2_ctl;
      s3_src  <= s2_src;
      s3_dmul <= s3_dmul_next;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: saturating add, or the copy case source as is, into the output register
  // ---------------------------------------------------------------------
  logic [PW-1:0] s4_pixel, s4_pixel_next;
  logic          s4_last;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      s4_pixel_next[CW*k +: CW] = argb_pkg::addsat8(s3_src[CW*k +: CW],
                                                    s3_dmul[CW*k +: CW]);
    end
    if (s3_ctl.copy) begin
      s4_pixel_next = s3_src;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      s4_pixel <= s4_pixel_next;
      s4_last  <= s3_ctl.last;
    end
  end

  assign out_valid    = v4;
  assign result_pixel = s4_pixel;
  assign last_out     = s4_last;

endmodule

FILE: hdl/argb_over_checker.sv
// ----------------------------------------------------------------------------
// argb_over_checker
// port-level checks for the argb over compositor, bound to the top level
// ----------------------------------------------------------------------------
module argb_over_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [argb_pkg::PIX_W-1:0]     result_pixel,
  input logic                           last_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_pixel) && $stable(last_out))
    else $error("result item changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  // with the output register empty the pipeline can always take an item
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule

bind argb_over_compositor_unit argb_over_checker u_argb_over_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_pixel (result_pixel),
  .last_out     (last_out)
);

FILE: tb/sv/tb_argb_over_compositor_unit.sv
// ----------------------------------------------------------------------------
// tb_argb_over_compositor_unit
// self-checking bench for the argb over compositor: a directed table of
// corner pixels and modes, then random pixel streams under every mode
// combination, each result held to a pinned value or a local blend predictor
// ----------------------------------------------------------------------------
module tb_argb_over_compositor_unit;

  localparam int unsigned CHAN_W = argb_pkg::CHAN_W;
  localparam int unsigned PIX_W = argb_pkg::PIX_W;
  localparam int unsigned NUM_CHAN = argb_pkg::NUM_CHAN;
  localparam int unsigned CFG_DATA_W = argb_pkg::CFG_DATA_W;
  localparam int unsigned CFG_IDX_W = argb_pkg::CFG_IDX_W;

  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned RST_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_PAD = 12;
  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned SEGS_PER_PHASE = 6;
  localparam int unsigned SEG_ITEMS = 47;
  localparam int unsigned NUM_FLAG_COMBOS = 16;
  localparam int unsigned NUM_DIR = 23;

  // register indexes past the solid color, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = argb_pkg::CFG_SOLID_COLOR + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

  // idle percentages per phase: sender busy first, then receiver, then none
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{27, 50, 0};
  localparam int RECV_IDLE_PCT [NUM_PHASES] = '{50, 27, 0};

  // mode register image
  typedef struct packed {
    logic             src_opq;
    logic             dst_opq;
    logic             mask_on;
    logic             solid_on;
    logic [PIX_W-1:0] color;
  } comp_mode_t;

  // one expected result item
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             last;
  } out_pix_t;

  // one directed row: mode, input item, and a typed-in result where obvious
  typedef struct packed {
    comp_mode_t        mode;
    logic [PIX_W-1:0]  src;
    logic [PIX_W-1:0]  dst;
    logic [CHAN_W-1:0] mask;
    logic              last;
    logic              pinned;
    logic [PIX_W-1:0]  want;
  } dir_row_t;

  localparam comp_mode_t MODE_PLAIN     = '{1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_COPY      = '{1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_SRC_OPQ   = '{1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_DST_OPQ   = '{1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_OPQ_MASK  = '{1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_MASK      = '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_0000};
  localparam comp_mode_t MODE_SOLID_NIL = '{1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000};
  localparam comp_mode_t MODE_SOLID_WHT = '{1'b1, 1'b1, 1'b0, 1'b1, 32'hffff_ffff};
  localparam comp_mode_t MODE_SOLID_CLR = '{1'b1, 1'b1, 1'b0, 1'b1, 32'h0020_4060};
  localparam comp_mode_t MODE_SOLID_ALL = '{1'b1, 1'b1, 1'b1, 1'b1, 32'hc080_6040};
  localparam comp_mode_t MODE_SOLID_MSK = '{1'b0, 1'b0, 1'b1, 1'b1, 32'hffff_ffff};
  localparam comp_mode_t MODE_SOLID_GRN = '{1'b0, 1'b0, 1'b0, 1'b1, 32'hff00_ff00};

  // directed rows, pinned results only where the arithmetic is trivial
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // reset mode: zero source leaves the destination
    '{MODE_PLAIN, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 32'h0000_0000},
    '{MODE_PLAIN, 32'h0000_0000, 32'hffff_ffff, 8'hff, 1'b1, 1'b1, 32'hffff_ffff},
    // opaque source pixel hides the destination
    '{MODE_PLAIN, 32'hffff_ffff, 32'hffff_ffff, 8'h00, 1'b0, 1'b1, 32'hffff_ffff},
    '{MODE_PLAIN, 32'hff00_0000, 32'h1234_5678, 8'h5a, 1'b1, 1'b1, 32'hff00_0000},
    // color above alpha, clamped by the saturating add, then a plain blend
    '{MODE_PLAIN, 32'h80ff_40ff, 32'hffff_ffff, 8'h00, 1'b0, 1'b0, 32'h0},
    '{MODE_PLAIN, 32'h4010_2030, 32'h8080_8080, 8'h00, 1'b1, 1'b0, 32'h0},
    // copy case: top byte passes through untouched
    '{MODE_COPY, 32'h0012_3456, 32'ha5a5_a5a5, 8'h00, 1'b0, 1'b1, 32'h0012_3456},
    '{MODE_COPY, 32'hffff_ffff, 32'h0000_0000, 8'hff, 1'b1, 1'b1, 32'hffff_ffff},
    '{MODE_COPY, 32'h7f80_ff01, 32'h5555_aaaa, 8'h33, 1'b0, 1'b1, 32'h7f80_ff01},
    // opaque source alone forces alpha to full
    '{MODE_SRC_OPQ, 32'h0012_3456, 32'hffff_ffff, 8'h00, 1'b1, 1'b1, 32'hff12_3456},
    '{MODE_DST_OPQ, 32'h4010_2030, 32'h8080_8080, 8'h00, 1'b0, 1'b0, 32'h0},
    // opaque source with mask: zero mask keeps dst, full mask keeps src
    '{MODE_OPQ_MASK, 32'hffff_ffff, 32'h89ab_cdef, 8'h00, 1'b0, 1'b1, 32'h89ab_cdef},
    '{MODE_OPQ_MASK, 32'h0012_3456, 32'h89ab_cdef, 8'hff, 1'b1, 1'b1, 32'hff12_3456},
    '{MODE_OPQ_MASK, 32'h0012_3456, 32'h89ab_cdef, 8'h80, 1'b0, 1'b0, 32'h0},
    '{MODE_MASK, 32'hc060_4020, 32'h4040_4040, 8'h7f, 1'b1, 1'b0, 32'h0},
    '{MODE_MASK, 32'hffff_ffff, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 32'h0000_0000},
    // solid source: input pixel ignored, opaque flag and copy case not applied
    '{MODE_SOLID_NIL, 32'hffff_ffff, 32'h1357_9bdf, 8'hff, 1'b0, 1'b1, 32'h1357_9bdf},
    '{MODE_SOLID_WHT, 32'h0000_0000, 32'h1234_5678, 8'h00, 1'b1, 1'b1, 32'hffff_ffff},
    '{MODE_SOLID_CLR, 32'hffff_ffff, 32'h1010_1010, 8'h00, 1'b0, 1'b1, 32'h1030_5070},
    '{MODE_SOLID_ALL, 32'h1234_5678, 32'hffff_ffff, 8'h7f, 1'b1, 1'b0, 32'h0},
    '{MODE_SOLID_MSK, 32'h0000_0000, 32'h8080_8080, 8'h00, 1'b0, 1'b1, 32'h8080_8080},
    '{MODE_SOLID_MSK, 32'h0000_0000, 32'h8080_8080, 8'hff, 1'b1, 1'b1, 32'hffff_ffff},
    '{MODE_SOLID_GRN, 32'h0000_0000, 32'hffff_ffff, 8'h00, 1'b0, 1'b1, 32'hff00_ff00}
  };

  // block ports, every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      src_pixel = '0;
  logic [PIX_W-1:0]      dst_pixel = '0;
  logic [CHAN_W-1:0]     mask_alpha = '0;
  logic                  row_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      result_pixel;
  logic                  last_out;

  // bench state
  comp_mode_t       cur_mode = MODE_PLAIN;
  out_pix_t         pending_pix[$];
  logic             pin_on = 1'b0;
  logic [PIX_W-1:0] pin_px = '0;
  int               err_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = SEND_IDLE_PCT[0];
  int               recv_idle_pct = RECV_IDLE_PCT[0];

  always #(CLK_HALF) clk = ~clk;

  argb_over_compositor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .src_pixel    (src_pixel),
    .dst_pixel    (dst_pixel),
    .mask_alpha   (mask_alpha),
    .row_end      (row_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_pixel (result_pixel),
    .last_out     (last_out)
  );

  // rounded a*b/255: bias, fold the high byte back in, keep the high byte
  function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [2*CHAN_W:0] t;
    t = a * b + 17'd128;
    t = (t >> CHAN_W) + t;
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

  // channel add clamped at full scale
  function automatic logic [CHAN_W-1:0] sat_add8(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = a + b;
    return (s > 9'(argb_pkg::CHAN_MAX)) ? argb_pkg::CHAN_MAX : s[CHAN_W-1:0];
  endfunction

  // over blend of one item under the given mode; channel 3 is alpha
  function automatic logic [PIX_W-1:0] over_blend(input comp_mode_t m,
                                                  input logic [PIX_W-1:0] src,
                                                  input logic [PIX_W-1:0] dst,
                                                  input logic [CHAN_W-1:0] mask);
    logic [PIX_W-1:0]  s_px;
    logic [PIX_W-1:0]  r;
    logic [CHAN_W-1:0] s_ch [NUM_CHAN];
    logic [CHAN_W-1:0] inv;
    int                k;
    // opaque pixel onto opaque surface without mask is a plain copy
    if (!m.solid_on && m.src_opq && m.dst_opq && !m.mask_on)
      return src;
    s_px = m.solid_on ? m.color : src;
    for (k = 0; k < NUM_CHAN; k++)
      s_ch[k] = s_px[CHAN_W*k +: CHAN_W];
    // opaque flag only touches a pixel source, never the solid color
    if (!m.solid_on && m.src_opq)
      s_ch[NUM_CHAN-1] = argb_pkg::CHAN_MAX;
    if (m.mask_on)
      for (k = 0; k < NUM_CHAN; k++)
        s_ch[k] = scale8(s_ch[k], mask);
    inv = argb_pkg::CHAN_MAX - s_ch[NUM_CHAN-1];
    for (k = 0; k < NUM_CHAN; k++)
      r[CHAN_W*k +: CHAN_W] = sat_add8(s_ch[k], scale8(dst[CHAN_W*k +: CHAN_W], inv));
    return r;
  endfunction

  // mostly premultiplied pixels, with extremes and raw noise mixed in
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [CHAN_W-1:0] a;
    logic [PIX_W-1:0]  p;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      2, 3: p = $urandom;
      default: begin
        if ($urandom_range(0, 3) == 0)
          a = $urandom_range(0, 1) ? argb_pkg::CHAN_MAX : 8'h00;
        else
          a = 8'($urandom);
        p = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
             8'($urandom_range(0, a))};
      end
    endcase
    return p;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return argb_pkg::CHAN_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver side: stall at random, per phase
  always @(negedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // scoreboard: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    out_pix_t exp_pix;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_pix.size() == 0) begin
          $display("%0t: unexpected item result_pixel %h last_out %b",
                   $time, result_pixel, last_out);
          err_count++;
        end else begin
          exp_pix = pending_pix.pop_front();
          if (result_pixel !== exp_pix.px) begin
            $display("%0t: result_pixel expected %h actual %h",
                     $time, exp_pix.px, result_pixel);
            err_count++;
          end
          if (last_out !== exp_pix.last) begin
            $display("%0t: last_out expected %b actual %b",
                     $time, exp_pix.last, last_out);
            err_count++;
          end
        end
      end
      // config is stable while items are in flight, so predict right here
      if (in_valid && in_ready)
        pending_pix.push_back('{pin_on ? pin_px :
                                over_blend(cur_mode, src_pixel, dst_pixel, mask_alpha),
                                row_end});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("** argb_over_compositor_unit: FAILED **");
      $finish;
    end
  end

  // offer one item after a random gap, return at the falling edge after it
  // is taken
  task automatic send_item(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst,
                           input logic [CHAN_W-1:0] mask, input logic last,
                           input logic pin, input logic [PIX_W-1:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    src_pixel  <= src;
    dst_pixel  <= dst;
    mask_alpha <= mask;
    row_end    <= last;
    pin_on     <= pin;
    pin_px     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait until every item has come out
  task automatic drain_items();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pix.size() != 0) @(negedge clk);
  endtask

  // one register write per cycle; the caller drops the write enable
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // write every register, plus one junk write to a dropped index; flag
  // registers get random upper bits that must be ignored
  task automatic apply_mode(input comp_mode_t m);
    put_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
    put_reg(argb_pkg::CFG_SRC_OPAQUE, {31'($urandom), m.src_opq});
    put_reg(argb_pkg::CFG_DST_OPAQUE, {31'($urandom), m.dst_opq});
    put_reg(argb_pkg::CFG_USE_MASK, {31'($urandom), m.mask_on});
    put_reg(argb_pkg::CFG_USE_SOLID, {31'($urandom), m.solid_on});
    put_reg(argb_pkg::CFG_SOLID_COLOR, m.color);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    comp_mode_t m;
    dir_row_t   r;
    int         k;
    int         p;
    int         s;
    int         n;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, registers rewritten whenever the row's mode changes
    for (k = 0; k < NUM_DIR; k++) begin
      r = DIR_ROWS[k];
      if (k == 0 || r.mode != cur_mode) begin
        drain_items();
        apply_mode(r.mode);
      end
      send_item(r.src, r.dst, r.mask, r.last, r.pinned, r.want);
    end

    // random part: the first sixteen segments walk every flag combination
    for (p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      recv_idle_pct = RECV_IDLE_PCT[p];
      for (s = 0; s < SEGS_PER_PHASE; s++) begin
        n = p * SEGS_PER_PHASE + s;
        m.color = rand_pixel();
        if (n < NUM_FLAG_COMBOS)
          {m.solid_on, m.mask_on, m.dst_opq, m.src_opq} = 4'(n);
        else
          {m.solid_on, m.mask_on, m.dst_opq, m.src_opq} = 4'($urandom);
        drain_items();
        apply_mode(m);
        repeat (SEG_ITEMS)
          send_item(rand_pixel(), rand_pixel(), rand_mask(),
                    $urandom_range(0, 7) == 0, 1'b0, '0);
      end
    end

    // let the pipeline empty, then watch a little longer for strays
    drain_items();
    repeat (DRAIN_PAD) @(posedge clk);
    if (err_count == 0)
      $display("** argb_over_compositor_unit: PASSED **");
    else
      $display("** argb_over_compositor_unit: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hdl/argb_pkg.sv
hdl/argb_over_compositor_unit.sv
hdl/argb_over_checker.sv
tb/sv/tb_argb_over_compositor_unit.sv
